FILE: hdl/cma_pkg.sv
// Shared types, constants and widths for the calibrated moisture averager.
package cma_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int ADC_BITS     = 10;
  localparam int CHAN_W       = 3;
  localparam int SAMPLE_W     = 10;
  localparam int SUM_W        = 16;
  localparam int CNT_W        = 7;
  localparam int SPA_W        = 7;
  localparam int PCT_W        = 7;
  localparam int DIV_W        = 17;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [ADC_BITS-1:0] ADC_MAX   = {ADC_BITS{1'b1}};
  localparam logic [SPA_W-1:0]    SPA_MAX   = 7'd64;
  localparam logic [SPA_W-1:0]    SPA_MIN   = 7'd1;
  localparam logic [SPA_W-1:0]    SPA_RESET = 7'd40;
  localparam logic [CNT_W-1:0]    CNT_SAT   = 7'd127;
  localparam logic [PCT_W-1:0]    PCT_FULL  = 7'd100;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_MEAS = 2'd0;
  localparam cmd_t CMD_DRY  = 2'd1;
  localparam cmd_t CMD_WET  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_CAP_SENSOR = 2'd0;
  localparam reg_idx_t REG_SPA        = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted request
    logic update;     // update the channel entry
    logic div_start;  // start the shared divider
    logic div_pct;    // divider operands: 1 percent mapping, 0 average
    logic emit;       // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic cal_err;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hdl/cma_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module cma_div #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_BITS = (W > 1) ? $clog2(W) : 1;
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(W - 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [W-1:0]        rem;
  logic [W-1:0]        quo;
  logic [W-1:0]        dsr;
  logic [W:0]          shifted;
  logic [W:0]          trial;
  logic                fits;

  assign shifted  = {rem, quo[W-1]};
  assign trial    = shifted - {1'b0, dsr};
  assign fits     = shifted >= {1'b0, dsr};
  assign done     = busy && (cnt == LAST);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule

FILE: hdl/cma_datapath.sv
// Datapath: channel tables, configuration, clamp and accumulate, divider, output register.
module cma_datapath #(
  parameter int CHANNELS = cma_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cma_pkg::ctrl_cmd_t             cmd,
  output cma_pkg::dp_status_t            status,
  input  logic [cma_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [cma_pkg::S_TUSER_W-1:0]  s_tuser,
  input  logic                           cfg_valid,
  input  logic [cma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cma_pkg::CFG_DAT_W-1:0]  cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cma_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [cma_pkg::M_TUSER_W-1:0]  m_tuser
);

  import cma_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic [ADC_BITS-1:0] track(input logic [ADC_BITS-1:0] cur,
                                                input logic [ADC_BITS-1:0] x,
                                                input logic keep_min,
                                                input logic reload);
    logic [ADC_BITS-1:0] base;
    base = reload ? (keep_min ? ADC_MAX : '0) : cur;
    if (keep_min) begin
      return (x < base) ? x : base;
    end
    return (x > base) ? x : base;
  endfunction

  // Configuration registers.
  logic             cap_sensor;
  logic [SPA_W-1:0] spa;
  logic [SPA_W-1:0] spa_eff;

  // Captured request.
  cmd_t                in_cmd;
  logic [CHAN_W-1:0]   in_ch;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_restart;

  // Per-channel state.
  logic [SUM_W-1:0]    sum_mem [CHANNELS];
  logic [CNT_W-1:0]    cnt_mem [CHANNELS];
  logic [ADC_BITS-1:0] dry_mem [CHANNELS];
  logic [ADC_BITS-1:0] wet_mem [CHANNELS];

  logic [CH_W-1:0]     idx;
  logic                ch_ok;
  logic [SUM_W-1:0]    cur_sum;
  logic [CNT_W-1:0]    cur_cnt;
  logic [ADC_BITS-1:0] cur_dry;
  logic [ADC_BITS-1:0] cur_wet;
  logic [ADC_BITS-1:0] x;
  logic [ADC_BITS-1:0] x_clamped;
  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]    cnt_next;
  logic                is_meas;
  logic                window_full;

  // Percent mapping.
  logic [SUM_W-1:0]    avg;
  logic                num_neg;
  logic                den_neg;
  logic [SUM_W-1:0]    avg_diff;
  logic [ADC_BITS-1:0] num_diff;
  logic [ADC_BITS-1:0] den_mag;
  logic [DIV_W-1:0]    num_mag;
  logic                q_neg;
  logic [PCT_W-1:0]    pct_calc;

  // Divider.
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quo;
  logic             div_done;

  // Output register.
  logic              out_valid;
  logic [CHAN_W-1:0] out_ch;
  logic [PCT_W-1:0]  out_pct;
  logic              out_err;

  always_comb begin
    if (spa == '0) begin
      spa_eff = SPA_MIN;
    end else if (spa > SPA_MAX) begin
      spa_eff = SPA_MAX;
    end else begin
      spa_eff = spa;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_sensor <= 1'b1;
      spa        <= SPA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAP_SENSOR: cap_sensor <= cfg_data[0];
        REG_SPA:        spa        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_ch      <= s_tdata[CHAN_W-1:0];
      in_sample  <= s_tdata[CHAN_W +: SAMPLE_W];
      in_cmd     <= s_tuser[1:0];
      in_restart <= s_tuser[2];
    end
  end

  assign idx     = CH_W'(in_ch);
  assign ch_ok   = int'(in_ch) < CHANNELS;
  assign cur_sum = sum_mem[idx];
  assign cur_cnt = cnt_mem[idx];
  assign cur_dry = dry_mem[idx];
  assign cur_wet = wet_mem[idx];
  assign x       = in_sample[ADC_BITS-1:0];

  // The wet bound is checked first, so when the calibration points are crossed it wins for samples below it.
  always_comb begin
    if (x < cur_wet) begin
      x_clamped = cur_wet;
    end else if (x > cur_dry) begin
      x_clamped = cur_dry;
    end else begin
      x_clamped = x;
    end
  end

  assign sum_next    = cur_sum + SUM_W'(x_clamped);
  assign cnt_next    = (cur_cnt == CNT_SAT) ? cur_cnt : cur_cnt + 1'b1;
  assign is_meas     = ch_ok && (in_cmd == CMD_MEAS);
  assign window_full = cnt_next >= spa_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_mem[i] <= '0;
        cnt_mem[i] <= '0;
        dry_mem[i] <= '0;
        wet_mem[i] <= '0;
      end
    end else if (cmd.update && ch_ok) begin
      case (in_cmd)
        CMD_MEAS: begin
          sum_mem[idx] <= window_full ? '0 : sum_next;
          cnt_mem[idx] <= window_full ? '0 : cnt_next;
        end
        CMD_DRY: dry_mem[idx] <= track(cur_dry, x, cap_sensor, in_restart);
        CMD_WET: wet_mem[idx] <= track(cur_wet, x, !cap_sensor, in_restart);
        default: ;
      endcase
    end
  end

  // The average sits in the divider's quotient once the first division ends.
  // It can exceed full scale when the window was shortened while samples were pending.
  assign avg      = div_quo[SUM_W-1:0];
  assign num_neg  = avg > SUM_W'(cur_wet);
  assign avg_diff = num_neg ? (avg - SUM_W'(cur_wet)) : (SUM_W'(cur_wet) - avg);
  // A distance beyond full scale already puts the quotient at 100 or more.
  assign num_diff = (avg_diff > SUM_W'(ADC_MAX)) ? ADC_MAX : avg_diff[ADC_BITS-1:0];
  assign num_mag  = DIV_W'(num_diff) * DIV_W'(PCT_FULL);
  assign den_neg  = cur_wet > cur_dry;
  assign den_mag  = den_neg ? (cur_wet - cur_dry) : (cur_dry - cur_wet);

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_pct) begin
      q_neg <= num_neg ^ den_neg;
    end
  end

  assign div_dividend = cmd.div_pct ? num_mag : DIV_W'(sum_next);
  assign div_divisor  = cmd.div_pct ? DIV_W'(den_mag) : DIV_W'(spa_eff);

  cma_div #(
    .W(DIV_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quo)
  );

  // A positive quotient always saturates at the wet end.
  always_comb begin
    if (!q_neg) begin
      pct_calc = PCT_FULL;
    end else if (div_quo >= DIV_W'(PCT_FULL)) begin
      pct_calc = '0;
    end else begin
      pct_calc = PCT_FULL - div_quo[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch  <= in_ch;
      out_err <= status.cal_err;
      out_pct <= status.cal_err ? '0 : pct_calc;
    end
  end

  assign status.has_result = is_meas && window_full;
  assign status.cal_err    = cur_dry == cur_wet;
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - PCT_W - CHAN_W)'(0), out_pct, out_ch};
  assign m_tuser  = out_err;

endmodule

FILE: hdl/cma_ctrl.sv
// Controller state machine that sequences accept, update, divisions and result output.
module cma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  cma_pkg::dp_status_t  status,
  output cma_pkg::ctrl_cmd_t   cmd
);

  import cma_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UPDATE = 6'b000010,
    S_AVG    = 6'b000100,
    S_MAP    = 6'b001000,
    S_PCT    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (!status.has_result) begin
          state_next = S_IDLE;
        end else if (status.cal_err) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_AVG;
        end
      end
      S_AVG: begin
        if (status.div_done) begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.div_start = 1'b1;
        cmd.div_pct   = 1'b1;
        state_next    = S_PCT;
      end
      S_PCT: begin
        cmd.div_pct = 1'b1;
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/calibrated_moisture_averager.sv
// Top level of the calibrated moisture averager.
//
// Requests arrive on the s_ stream: one sample for one channel with a command
// (measure, dry calibration, wet calibration) and a restart flag. Calibration
// requests update the channel's dry or wet point and produce no result.
// Measurement requests are clamped and summed per channel; when the channel's
// window is full one result (channel, percent, error flag) leaves on m_.
// Configuration writes on cfg_ (index 0 sensor type, 1 samples per average)
// are always ready and must only be issued while the block is idle.
// Sequence: a request without a result passes through accept and update.
// A request that fills a window passes through accept, update, two
// passes of the shared bit-serial divider (average, then percent
// mapping) with one setup state between them, and one load into the output
// register, after which m_tvalid rises. With equal calibration points the
// divider is skipped: the error result is loaded after update, and the
// block takes a new request once that load is done.
// The output register holds a result while m_tready is low; the block keeps
// taking requests until it has a new result to load, then waits.
// Reset clears all channel state and restores the configuration defaults.
module calibrated_moisture_averager #(
  parameter int CHANNELS = cma_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // channel[2:0], sample[12:3], zero[15:13]
  input  logic [cma_pkg::S_TDATA_W-1:0]  s_tdata,
  // cmd[1:0], restart[2]
  input  logic [cma_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_channel[2:0], percent[9:3], zero[15:10]
  output logic [cma_pkg::M_TDATA_W-1:0]  m_tdata,
  // cal_error[0]
  output logic [cma_pkg::M_TUSER_W-1:0]  m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cma_pkg::CFG_DAT_W-1:0]  cfg_data
);

  import cma_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  cma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  cma_datapath #(
    .CHANNELS(CHANNELS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the calibrated moisture averager.
module tb;
  import cma_pkg::*;

  localparam cmd_t     CMD_UNUSED   = 2'd3;
  localparam reg_idx_t REG_UNUSED_2 = 2'd2;
  localparam reg_idx_t REG_UNUSED_3 = 2'd3;

  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int TARGET_ITEMS  = 1950;

  typedef enum logic [1:0] {OP_SAMPLE, OP_CONFIG, OP_PAUSE} op_kind_t;
  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_t;

  typedef struct {
    op_kind_t              kind;
    cmd_t                  cmd;
    logic [CHAN_W-1:0]     ch;
    logic [SAMPLE_W-1:0]   sample;
    logic                  restart;
    reg_idx_t              idx;
    logic [CFG_DAT_W-1:0]  data;
  } req_t;

  typedef struct {
    logic [CHAN_W-1:0] ch;
    logic [PCT_W-1:0]  pct;
    logic              err;
  } moisture_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  reg_idx_t             cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  calibrated_moisture_averager uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  req_t      req_q[$];
  moisture_t moisture_q[$];
  int        fail_cnt = 0;
  int        sample_total = 0;

  // Predictor state, one entry per channel.
  logic [SUM_W-1:0]    acc_sum[CHANNELS_DEF];
  logic [CNT_W-1:0]    acc_cnt[CHANNELS_DEF];
  logic [SAMPLE_W-1:0] dry_pt[CHANNELS_DEF];
  logic [SAMPLE_W-1:0] wet_pt[CHANNELS_DEF];
  logic                cap_mode;
  logic [SPA_W-1:0]    avg_len;

  function automatic logic [SAMPLE_W-1:0] track_point(input logic [SAMPLE_W-1:0] cur,
                                                      input logic [SAMPLE_W-1:0] x,
                                                      input logic keep_min, reload);
    logic [SAMPLE_W-1:0] base;
    base = reload ? (keep_min ? ADC_MAX : '0) : cur;
    if (keep_min) begin
      return (x < base) ? x : base;
    end
    return (x > base) ? x : base;
  endfunction

  task automatic predict_moisture(input req_t r);
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] wet;
    logic [SAMPLE_W-1:0] dry;
    int                  spa;
    int                  avg;
    int                  p;
    moisture_t           res;
    x = r.sample;
    if (r.cmd == CMD_DRY) begin
      dry_pt[r.ch] = track_point(dry_pt[r.ch], x, cap_mode, r.restart);
    end else if (r.cmd == CMD_WET) begin
      wet_pt[r.ch] = track_point(wet_pt[r.ch], x, !cap_mode, r.restart);
    end else if (r.cmd == CMD_MEAS) begin
      wet = wet_pt[r.ch];
      dry = dry_pt[r.ch];
      if (x < wet) begin
        x = wet;
      end else if (x > dry) begin
        x = dry;
      end
      acc_sum[r.ch] = acc_sum[r.ch] + SUM_W'(x);
      if (acc_cnt[r.ch] < CNT_SAT) begin
        acc_cnt[r.ch] = acc_cnt[r.ch] + 1'b1;
      end
      if (avg_len == '0) begin
        spa = 1;
      end else if (avg_len > SPA_MAX) begin
        spa = int'(SPA_MAX);
      end else begin
        spa = int'(avg_len);
      end
      if (int'(acc_cnt[r.ch]) >= spa) begin
        avg = int'(acc_sum[r.ch]) / spa;
        res.ch  = r.ch;
        res.err = (dry == wet);
        res.pct = '0;
        if (!res.err) begin
          p = 100 + ((avg - int'(wet)) * -100) / (int'(dry) - int'(wet));
          if (p < 0) begin
            p = 0;
          end
          if (p > 100) begin
            p = 100;
          end
          res.pct = PCT_W'(p);
        end
        acc_sum[r.ch] = '0;
        acc_cnt[r.ch] = '0;
        moisture_q.push_back(res);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  req_t cur_req;
  int   gap_cnt = 0;
  int   burst_left = 1;
  int   settle_cnt = 0;

  always @(posedge clk) begin : drive_proc
    logic nxt_valid;
    logic nxt_cfg;
    req_t head;
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_valid <= 1'b0;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        acc_sum[i] = '0;
        acc_cnt[i] = '0;
        dry_pt[i]  = '0;
        wet_pt[i]  = '0;
      end
      cap_mode   = 1'b1;
      avg_len    = SPA_RESET;
      settle_cnt = 0;
    end else begin
      nxt_valid = s_tvalid;
      nxt_cfg   = cfg_valid;
      if (s_tvalid && s_tready) begin
        predict_moisture(cur_req);
        nxt_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CAP_SENSOR) begin
          cap_mode = cfg_data[0];
        end else if (cfg_index == REG_SPA) begin
          avg_len = cfg_data;
        end
        nxt_cfg = 1'b0;
      end
      if (!nxt_valid && !nxt_cfg && req_q.size() != 0) begin
        if (req_q[0].kind == OP_SAMPLE) begin
          if (gap_cnt != 0) begin
            gap_cnt--;
          end else begin
            head    = req_q.pop_front();
            cur_req = head;
            s_tdata <= {3'b000, head.sample, head.ch};
            s_tuser <= {head.restart, head.cmd};
            nxt_valid = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
              gap_cnt    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end
        end else if (moisture_q.size() != 0) begin
          // Registers change and pauses end only once the block has drained.
          settle_cnt = 0;
        end else if (settle_cnt < SETTLE_CYCLES) begin
          settle_cnt++;
        end else begin
          settle_cnt = 0;
          head = req_q.pop_front();
          if (head.kind == OP_CONFIG) begin
            cfg_index <= head.idx;
            cfg_data  <= head.data;
            nxt_cfg = 1'b1;
          end
        end
      end
      s_tvalid  <= nxt_valid;
      cfg_valid <= nxt_cfg;
    end
  end

  // --------------------------------------------------------------- monitor
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       hold_cnt = 0;
  int       results_seen = 0;

  always @(posedge clk) begin : check_proc
    moisture_t want;
    logic      nxt_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (moisture_q.size() == 0) begin
          $error("result with no request pending: channel %0d", m_tdata[CHAN_W-1:0]);
          fail_cnt++;
        end else begin
          want = moisture_q.pop_front();
          if (m_tdata[CHAN_W-1:0] !== want.ch) begin
            $error("out_channel: expected %0d, actual %0d", want.ch, m_tdata[CHAN_W-1:0]);
            fail_cnt++;
          end
          if (m_tdata[CHAN_W +: PCT_W] !== want.pct) begin
            $error("percent: expected %0d, actual %0d", want.pct, m_tdata[CHAN_W +: PCT_W]);
            fail_cnt++;
          end
          if (m_tuser[0] !== want.err) begin
            $error("cal_error: expected %0d, actual %0d", want.err, m_tuser[0]);
            fail_cnt++;
          end
        end
        if (results_seen == 25 || results_seen == 250) begin
          hold_cnt = LONG_HOLD;
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 150);
      end else begin
        rx_left--;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        nxt_ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   nxt_ready = 1'b1;
          RX_CHOPPY: nxt_ready = 1'($urandom_range(0, 1));
          default:   nxt_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      m_tready <= nxt_ready;
    end
  end

  // -------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic push_sample(input cmd_t cmd, input int ch, input int x, input logic restart);
    req_t r;
    r.kind    = OP_SAMPLE;
    r.cmd     = cmd;
    r.ch      = CHAN_W'(ch);
    r.sample  = SAMPLE_W'(x);
    r.restart = restart;
    r.idx     = '0;
    r.data    = '0;
    req_q.push_back(r);
    if (cmd != CMD_UNUSED) begin
      sample_total++;
    end
  endtask

  task automatic push_cfg(input reg_idx_t idx, input int data);
    req_t r;
    r.kind    = OP_CONFIG;
    r.cmd     = CMD_MEAS;
    r.ch      = '0;
    r.sample  = '0;
    r.restart = 1'b0;
    r.idx     = idx;
    r.data    = CFG_DAT_W'(data);
    req_q.push_back(r);
  endtask

  task automatic push_pause();
    req_t r;
    r.kind    = OP_PAUSE;
    r.cmd     = CMD_MEAS;
    r.ch      = '0;
    r.sample  = '0;
    r.restart = 1'b0;
    r.idx     = '0;
    r.data    = '0;
    req_q.push_back(r);
  endtask

  function automatic int rand_level(input logic high);
    return high ? $urandom_range(600, 1023) : $urandom_range(0, 450);
  endfunction

  task automatic fill_phase(input int n);
    int   focus;
    int   ch;
    int   r;
    int   v;
    logic dry_high;
    focus = $urandom_range(0, CHANNELS_DEF - 1);
    for (int k = 0; k < n; k++) begin
      ch = $urandom_range(0, 1) ? focus : $urandom_range(0, CHANNELS_DEF - 1);
      r  = $urandom_range(0, 99);
      if (r < 10) begin
        // Full calibration window: restart each tracker, then a few more points.
        dry_high = ($urandom_range(0, 3) != 0);
        push_sample(CMD_DRY, ch, rand_level(dry_high), 1'b1);
        repeat ($urandom_range(0, 3)) push_sample(CMD_DRY, ch, rand_level(dry_high), 1'b0);
        push_sample(CMD_WET, ch, rand_level(!dry_high), 1'b1);
        repeat ($urandom_range(0, 3)) push_sample(CMD_WET, ch, rand_level(!dry_high), 1'b0);
      end else if (r < 13) begin
        // Both points restarted on the same value leave them equal.
        v = $urandom_range(0, 1023);
        push_sample(CMD_DRY, ch, v, 1'b1);
        push_sample(CMD_WET, ch, v, 1'b1);
      end else if (r < 88) begin
        push_sample(CMD_MEAS, ch, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
      end else if (r < 96) begin
        push_sample($urandom_range(0, 1) ? CMD_DRY : CMD_WET, ch, $urandom_range(0, 1023),
                    1'($urandom_range(0, 1)));
      end else begin
        push_sample(CMD_UNUSED, ch, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int spa_sel;
    int spa;

    // Directed part.
    push_cfg(REG_CAP_SENSOR, 1);
    push_cfg(REG_SPA, 1);
    push_sample(CMD_MEAS, 0, 0, 1'b0);      // uncalibrated channel: equal points
    push_sample(CMD_DRY, 1, 900, 1'b1);
    push_sample(CMD_DRY, 1, 1000, 1'b0);
    push_sample(CMD_DRY, 1, 850, 1'b0);
    push_sample(CMD_WET, 1, 200, 1'b1);
    push_sample(CMD_WET, 1, 100, 1'b0);
    push_sample(CMD_WET, 1, 300, 1'b0);
    push_sample(CMD_MEAS, 1, 0, 1'b0);
    push_sample(CMD_MEAS, 1, 1023, 1'b0);
    push_sample(CMD_MEAS, 1, 575, 1'b1);
    push_sample(CMD_UNUSED, 1, 777, 1'b1);
    push_sample(CMD_DRY, 7, 1023, 1'b1);
    push_sample(CMD_WET, 7, 0, 1'b1);
    push_sample(CMD_MEAS, 7, 512, 1'b0);
    push_pause();
    push_cfg(REG_CAP_SENSOR, 0);
    push_cfg(REG_SPA, 0);
    push_sample(CMD_DRY, 2, 100, 1'b1);
    push_sample(CMD_DRY, 2, 50, 1'b0);
    push_sample(CMD_WET, 2, 800, 1'b1);
    push_sample(CMD_WET, 2, 900, 1'b0);
    push_sample(CMD_MEAS, 2, 300, 1'b0);
    push_sample(CMD_MEAS, 2, 900, 1'b0);
    push_cfg(REG_SPA, 127);
    push_cfg(REG_UNUSED_2, 127);
    push_cfg(REG_UNUSED_3, 0);
    push_sample(CMD_DRY, 5, 700, 1'b1);
    push_sample(CMD_WET, 5, 100, 1'b1);
    repeat (3) push_sample(CMD_MEAS, 5, $urandom_range(0, 1023), 1'b0);
    push_cfg(REG_SPA, 2);                   // window shrinks below the count
    push_sample(CMD_MEAS, 5, 400, 1'b0);

    // Random part, in phases with fresh register settings.
    while (sample_total < TARGET_ITEMS) begin
      spa_sel = $urandom_range(0, 19);
      case (spa_sel)
        0:       spa = 0;
        1:       spa = 127;
        2:       spa = 64;
        3:       spa = $urandom_range(5, 40);
        default: spa = $urandom_range(1, 4);
      endcase
      push_cfg(REG_CAP_SENSOR, $urandom_range(0, 1));
      push_cfg(REG_SPA, spa);
      fill_phase($urandom_range(40, 160));
      if ($urandom_range(0, 4) == 0) begin
        push_pause();
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || s_tvalid || cfg_valid || moisture_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cma_pkg.sv
hdl/cma_div.sv
hdl/cma_datapath.sv
hdl/cma_ctrl.sv
hdl/calibrated_moisture_averager.sv
tb/sv/tb.sv
